/* hdl/aabb_transform_plane_classify_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the box transform and plane classify block
// Shared property forms so that every check reads the same way.
// ----------------------------------------------------------------------------
`ifndef AABB_TRANSFORM_PLANE_CLASSIFY_ASSERT_SVH
`define AABB_TRANSFORM_PLANE_CLASSIFY_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define ATPC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ATPC_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hdl/atpc_pkg.sv */
// ----------------------------------------------------------------------------
// atpc_pkg
// Types, widths and codes shared by the box transform and plane classify block.
// ----------------------------------------------------------------------------
package atpc_pkg;

   localparam int COORD_W     = 16;
   localparam int CSR_W       = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int MAP_ACC_W   = 34;
   localparam int PLANE_ACC_W = 35;

   localparam logic [CSR_IDX_W-1:0] CSR_COL_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_Z = 2'd2;

   // Reset values form the identity map.
   localparam logic [CSR_W-1:0] COL_X_RESET = 64'h0000_0000_0000_1000;
   localparam logic [CSR_W-1:0] COL_Y_RESET = 64'h0000_0000_1000_0000;
   localparam logic [CSR_W-1:0] COL_Z_RESET = 64'h0000_1000_0000_0000;

   localparam logic [1:0] SIDE_FRONT = 2'd0;
   localparam logic [1:0] SIDE_BACK  = 2'd1;
   localparam logic [1:0] SIDE_CROSS = 2'd2;

   localparam logic MODE_LOAD     = 1'b0;
   localparam logic MODE_CLASSIFY = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic      mode;
      coord_type local_min_x;
      coord_type local_min_y;
      coord_type local_min_z;
      coord_type local_max_x;
      coord_type local_max_y;
      coord_type local_max_z;
      coord_type plane_a;
      coord_type plane_b;
      coord_type plane_c;
      coord_type plane_d;
   } req_payload_type;

   typedef struct packed {
      coord_type  world_min_x;
      coord_type  world_min_y;
      coord_type  world_min_z;
      coord_type  world_max_x;
      coord_type  world_max_y;
      coord_type  world_max_z;
      logic [1:0] plane_side;
   } rsp_payload_type;

endpackage

/* hdl/atpc_stream_if.sv */
// ----------------------------------------------------------------------------
// atpc_stream_if
// Valid/ready channel carrying one item payload.
// ----------------------------------------------------------------------------
interface atpc_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/atpc_axis_map.sv */
// ----------------------------------------------------------------------------
// atpc_axis_map
// Maps a local box onto one world axis and gives the extreme values.
// ----------------------------------------------------------------------------
module atpc_axis_map import atpc_pkg::*; (
   input  logic [CSR_W-1:0] col,
   input  coord_type        lo [3],
   input  coord_type        hi [3],
   output coord_type        world_min,
   output coord_type        world_max
);

   // The map is linear and rounding is monotonic, so the extreme corners
   // come from taking the smaller and larger product per term.
   logic signed [2*COORD_W-1:0] term_min [3];
   logic signed [2*COORD_W-1:0] term_max [3];
   logic signed [MAP_ACC_W-1:0] acc_min;
   logic signed [MAP_ACC_W-1:0] acc_max;
   coord_type                   offset;

   for (genvar i = 0; i < 3; i++) begin : g_term
      coord_type                   weight;
      logic signed [2*COORD_W-1:0] prod_lo;
      logic signed [2*COORD_W-1:0] prod_hi;
      assign weight  = coord_type'(col[COORD_W*i +: COORD_W]);
      assign prod_lo = weight * lo[i];
      assign prod_hi = weight * hi[i];
      assign term_min[i] = (prod_lo < prod_hi) ? prod_lo : prod_hi;
      assign term_max[i] = (prod_lo < prod_hi) ? prod_hi : prod_lo;
   end

   assign offset = coord_type'(col[CSR_W-1 -: COORD_W]);

   function automatic logic signed [MAP_ACC_W-1:0] sum3(
      input logic signed [2*COORD_W-1:0] a,
      input logic signed [2*COORD_W-1:0] b,
      input logic signed [2*COORD_W-1:0] c
   );
      logic signed [MAP_ACC_W-1:0] ea;
      logic signed [MAP_ACC_W-1:0] eb;
      logic signed [MAP_ACC_W-1:0] ec;
      ea = {{(MAP_ACC_W-2*COORD_W){a[2*COORD_W-1]}}, a};
      eb = {{(MAP_ACC_W-2*COORD_W){b[2*COORD_W-1]}}, b};
      ec = {{(MAP_ACC_W-2*COORD_W){c[2*COORD_W-1]}}, c};
      return ea + eb + ec + MAP_ACC_W'(2048);
   endfunction

   // Floor of the biased sum over 2^12, plus offset, saturated to 16 bits.
   function automatic coord_type round_sat(
      input logic signed [MAP_ACC_W-1:0] acc,
      input coord_type                   ofs
   );
      logic signed [MAP_ACC_W-12:0] sum;
      sum = {acc[MAP_ACC_W-1], acc[MAP_ACC_W-1:12]}
            + {{(MAP_ACC_W-11-COORD_W){ofs[COORD_W-1]}}, ofs};
      if (sum < -(MAP_ACC_W-11)'(32768)) begin
         return coord_type'(16'sh8000);
      end else if (sum > (MAP_ACC_W-11)'(32767)) begin
         return coord_type'(16'sh7fff);
      end
      return coord_type'(sum[COORD_W-1:0]);
   endfunction

   assign acc_min   = sum3(term_min[0], term_min[1], term_min[2]);
   assign acc_max   = sum3(term_max[0], term_max[1], term_max[2]);
   assign world_min = round_sat(acc_min, offset);
   assign world_max = round_sat(acc_max, offset);

endmodule

/* hdl/atpc_plane_test.sv */
// ----------------------------------------------------------------------------
// atpc_plane_test
// Classifies the stored world box against one plane.
// ----------------------------------------------------------------------------
module atpc_plane_test import atpc_pkg::*; (
   input  coord_type  normal [3],
   input  coord_type  plane_d,
   input  coord_type  lower  [3],
   input  coord_type  upper  [3],
   output logic [1:0] side
);

   logic signed [PLANE_ACC_W-1:0] dist_pos;
   logic signed [PLANE_ACC_W-1:0] dist_neg;
   logic signed [PLANE_ACC_W-1:0] ext_pos [3];
   logic signed [PLANE_ACC_W-1:0] ext_neg [3];
   logic signed [PLANE_ACC_W-1:0] d_scaled;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic                        n_pos;
      coord_type                   v_pos;
      coord_type                   v_neg;
      logic signed [2*COORD_W-1:0] p_pos;
      logic signed [2*COORD_W-1:0] p_neg;
      // A zero component counts as non-positive.
      assign n_pos = !normal[i][COORD_W-1] && (normal[i] != '0);
      assign v_pos = n_pos ? upper[i] : lower[i];
      assign v_neg = n_pos ? lower[i] : upper[i];
      assign p_pos = normal[i] * v_pos;
      assign p_neg = normal[i] * v_neg;
      assign ext_pos[i] = {{(PLANE_ACC_W-2*COORD_W){p_pos[2*COORD_W-1]}}, p_pos};
      assign ext_neg[i] = {{(PLANE_ACC_W-2*COORD_W){p_neg[2*COORD_W-1]}}, p_neg};
   end

   assign d_scaled = {{(PLANE_ACC_W-COORD_W-12){plane_d[COORD_W-1]}}, plane_d, 12'b0};
   assign dist_pos = d_scaled + ext_pos[0] + ext_pos[1] + ext_pos[2];
   assign dist_neg = d_scaled + ext_neg[0] + ext_neg[1] + ext_neg[2];

   always_comb begin
      priority if (dist_neg == '0) begin
         side = SIDE_CROSS;
      end else if (dist_neg[PLANE_ACC_W-1] && !dist_pos[PLANE_ACC_W-1]
                   && (dist_pos != '0)) begin
         side = SIDE_CROSS;
      end else if (!dist_neg[PLANE_ACC_W-1] && dist_pos[PLANE_ACC_W-1]) begin
         side = SIDE_CROSS;
      end else if (!dist_neg[PLANE_ACC_W-1]) begin
         side = SIDE_FRONT;
      end else begin
         side = SIDE_BACK;
      end
   end

endmodule

/* hdl/aabb_transform_plane_classify.sv */
// ----------------------------------------------------------------------------
// aabb_transform_plane_classify
// Transforms a local box into a stored world box, or tests that box against
// a plane, one item per cycle while rsp_if is not stalled.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req_if    in         mode, local box corners, plane a/b/c/d
//   rsp_if    out        stored world box after the item, plane side
//   csr_*     in         writes of col_x, col_y, col_z (index 0..2)
//
// An item is taken into the input register at the edge that accepts it and
// passes through the transform and plane logic into the result register once
// that register is empty or its item is being taken; rsp_if offers its result
// from the result register. One item is taken in every cycle while rsp_if is
// not stalled. The world box is updated at the same edge that loads the
// result, so a classify item directly behind a load already sees the new box.
// Reset is synchronous and active high; it restores the identity map and a
// zero world box. A stall on rsp_if holds the result register, and the input
// register keeps accepting until it too holds an item that cannot move.
//
`include "aabb_transform_plane_classify_assert.svh"

module aabb_transform_plane_classify import atpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   atpc_stream_if.sink          req_if,
   atpc_stream_if.source        rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Affine map, one register per world axis.
   logic [CSR_W-1:0] col_ff [3];

   // Stored world box.
   coord_type box_lower_ff [3];
   coord_type box_upper_ff [3];

   // Input register and result register.
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   logic req_accept;
   logic advance;
   logic do_load;

   coord_type  local_lo  [3];
   coord_type  local_hi  [3];
   coord_type  new_lower [3];
   coord_type  new_upper [3];
   coord_type  normal    [3];
   logic [1:0] side;

   // ---------------------------------------------------------------------
   // Configuration writes. Indexes past the last register are dropped.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff[0] <= COL_X_RESET;
         col_ff[1] <= COL_Y_RESET;
         col_ff[2] <= COL_Z_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COL_X: col_ff[0] <= csr_wdata;
            CSR_COL_Y: col_ff[1] <= csr_wdata;
            CSR_COL_Z: col_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake. The input register moves forward whenever the result
   // register is empty or its item is being taken in this cycle.
   // ---------------------------------------------------------------------
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_accept   = req_if.valid && req_if.ready;
   assign do_load      = advance && (in_data_ff.mode == MODE_LOAD);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_if.payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------------------------------------------------------------
   // Datapath: three axis mappers for loads, one plane tester for
   // classifies, both working from the input register.
   // ---------------------------------------------------------------------
   assign local_lo[0] = in_data_ff.local_min_x;
   assign local_lo[1] = in_data_ff.local_min_y;
   assign local_lo[2] = in_data_ff.local_min_z;
   assign local_hi[0] = in_data_ff.local_max_x;
   assign local_hi[1] = in_data_ff.local_max_y;
   assign local_hi[2] = in_data_ff.local_max_z;

   for (genvar k = 0; k < 3; k++) begin : g_map
      atpc_axis_map u_axis_map (
         .col       (col_ff[k]),
         .lo        (local_lo),
         .hi        (local_hi),
         .world_min (new_lower[k]),
         .world_max (new_upper[k])
      );
   end

   assign normal[0] = in_data_ff.plane_a;
   assign normal[1] = in_data_ff.plane_b;
   assign normal[2] = in_data_ff.plane_c;

   atpc_plane_test u_plane_test (
      .normal  (normal),
      .plane_d (in_data_ff.plane_d),
      .lower   (box_lower_ff),
      .upper   (box_upper_ff),
      .side    (side)
   );

   // The world box changes only on a load.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_lower_ff[i] <= '0;
            box_upper_ff[i] <= '0;
         end
      end else if (do_load) begin
         for (int i = 0; i < 3; i++) begin
            box_lower_ff[i] <= new_lower[i];
            box_upper_ff[i] <= new_upper[i];
         end
      end
   end

   // A load reports the new box and a front side; a classify reports the
   // box it was tested against.
   always_comb begin
      if (in_data_ff.mode == MODE_LOAD) begin
         rsp_data_in.world_min_x = new_lower[0];
         rsp_data_in.world_min_y = new_lower[1];
         rsp_data_in.world_min_z = new_lower[2];
         rsp_data_in.world_max_x = new_upper[0];
         rsp_data_in.world_max_y = new_upper[1];
         rsp_data_in.world_max_z = new_upper[2];
         rsp_data_in.plane_side  = SIDE_FRONT;
      end else begin
         rsp_data_in.world_min_x = box_lower_ff[0];
         rsp_data_in.world_min_y = box_lower_ff[1];
         rsp_data_in.world_min_z = box_lower_ff[2];
         rsp_data_in.world_max_x = box_upper_ff[0];
         rsp_data_in.world_max_y = box_upper_ff[1];
         rsp_data_in.world_max_z = box_upper_ff[2];
         rsp_data_in.plane_side  = side;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `ATPC_ASSERT_NEXT(a_classify_keeps_box, clock, reset,
      advance && (in_data_ff.mode == MODE_CLASSIFY),
      (box_lower_ff[0] == $past(box_lower_ff[0]))
         && (box_upper_ff[2] == $past(box_upper_ff[2])),
      "classify item changed the stored box")
   `ATPC_ASSERT_NEXT(a_load_box_ordered, clock, reset, do_load,
      (box_lower_ff[0] <= box_upper_ff[0]) && (box_lower_ff[1] <= box_upper_ff[1])
         && (box_lower_ff[2] <= box_upper_ff[2]),
      "loaded world box is not ordered")
   `ATPC_ASSERT_NEXT(a_load_side_front, clock, reset, do_load,
      rsp_valid_ff && (rsp_data_ff.plane_side == SIDE_FRONT),
      "load item did not report front")
   `ATPC_ASSERT_SAME(a_result_matches_box, clock, reset, rsp_valid_ff && !advance,
      (rsp_data_ff.world_min_x == box_lower_ff[0])
         && (rsp_data_ff.world_max_z == box_upper_ff[2]),
      "held result differs from the stored box")

endmodule
